### hdl/sorted_priority_queue_unit_assert.svh
// Assertion macros for the sorted priority queue.
// Define NO_ASSERTIONS to compile them out.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on clk_i, masked while rst_ni is low.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on clk_i at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hdl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned PRIO_BITS = 8;
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned CNT_BITS  = 5;

  // operation codes
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncRemove = 1'b1;

  typedef enum logic [1:0] {
    StsInserted = 2'd0,
    StsRemoved  = 2'd1,
    StsFull     = 2'd2,
    StsEmpty    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    Idle,
    PopData,
    InsWalk,
    InsLast,
    Done
  } state_e;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic                 func;
    logic [PRIO_BITS-1:0] priority_req;
    logic [TAG_BITS-1:0]  tag;
  } in_beat_t;

  typedef struct packed {
    status_e              status;
    logic [PRIO_BITS-1:0] out_priority;
    logic [TAG_BITS-1:0]  out_tag;
    logic [CNT_BITS-1:0]  count;
  } out_beat_t;

endpackage

### hdl/spq_ram.sv
module spq_ram #(
  parameter int unsigned Depth = spq_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  spq_pkg::entry_t          wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output spq_pkg::entry_t          rdata_o
);
  import spq_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sorted_priority_queue_unit.sv
// Sorted priority queue, lowest priority value served first, stable on ties.
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat is one
// operation, insert (priority_req, tag) or remove front. Output channel
// (out_valid_o / out_stall_i / out_data_o): exactly one result beat per
// input beat, in order: status, removed entry (zero unless removed), count.
// One operation is worked at a time; in_stall_o is high while it runs.
// Path from acceptance to the done state, where the result can be taken:
//   refused insert/remove, insert into empty queue: straight to done
//   remove: one registered read of the front entry, then done
//   insert: the tail is walked down one entry per cycle through the entry
//   RAM (one read and one write port), each entry with a priority above the
//   new one moved up by one slot, then the new entry written into the slot freed last.
// The next beat is taken the cycle after the result is handed to the output
// register, so a new operation may be accepted while a result still waits.
// Entries live in a ring in RAM; head pointer and count are flip-flops.
// Reset (rst_ni low, asynchronous) empties the queue at once: count and head
// cleared, no clearing pass, RAM contents left as they are.
// A stalled output holds its beat; a finished result then waits in the
// done state until the output register frees up.
`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spq_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spq_pkg::out_beat_t  out_data_o
);
  import spq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  // ring slot of logical position off
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   idx_q, idx_d;     // logical position under compare
  entry_t          new_q, new_d;     // entry being inserted
  out_beat_t       res_q, res_d;     // finished result
  out_beat_t       out_q;
  logic            out_valid_q;

  logic            in_fire;
  logic            out_free;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;
  logic            walk_gt;

  assign in_stall_o = (state_q != Idle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign walk_gt    = ram_rdata.prio > new_q.prio;

  spq_ram #(
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      Idle: begin
        if (in_fire) begin
          if (in_data_i.func == FuncRemove) begin
            state_d = (count_q == '0) ? Done : PopData;
          end else if (count_q == DepthC || count_q == '0) begin
            state_d = Done;
          end else begin
            state_d = InsWalk;
          end
        end
      end
      PopData: state_d = Done;
      InsWalk: begin
        if (!walk_gt) begin
          state_d = Done;
        end else if (idx_q == '0) begin
          state_d = InsLast;
        end
      end
      InsLast: state_d = Done;
      Done: begin
        if (out_free) begin
          state_d = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    count_d   = count_q;
    head_d    = head_q;
    idx_d     = idx_q;
    new_d     = new_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = new_q;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    unique case (state_q)
      Idle: begin
        if (in_fire) begin
          new_d.prio         = in_data_i.priority_req;
          new_d.tag          = in_data_i.tag;
          res_d.out_priority = '0;
          res_d.out_tag      = '0;
          res_d.count        = CNT_BITS'(count_q);
          if (in_data_i.func == FuncRemove) begin
            res_d.status = StsEmpty;
            ram_re       = (count_q != '0);
            ram_raddr    = head_q;
          end else if (count_q == DepthC) begin
            res_d.status = StsFull;
          end else if (count_q == '0) begin
            // empty queue: store at the head directly
            ram_we       = 1'b1;
            ram_waddr    = head_q;
            ram_wdata    = new_d;
            count_d      = count_q + CW'(1);
            res_d.status = StsInserted;
            res_d.count  = CNT_BITS'(count_d);
          end else begin
            // start the walk at the tail
            idx_d     = AW'(count_q - CW'(1));
            ram_re    = 1'b1;
            ram_raddr = phys(head_q, idx_d);
          end
        end
      end
      PopData: begin
        count_d            = count_q - CW'(1);
        head_d             = phys(head_q, AW'(1));
        res_d.status       = StsRemoved;
        res_d.out_priority = ram_rdata.prio;
        res_d.out_tag      = ram_rdata.tag;
        res_d.count        = CNT_BITS'(count_d);
      end
      InsWalk: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_q, idx_q + AW'(1));
        if (walk_gt) begin
          // move this entry up one slot, fetch the one below
          ram_wdata = ram_rdata;
          if (idx_q != '0) begin
            idx_d     = idx_q - AW'(1);
            ram_re    = 1'b1;
            ram_raddr = phys(head_q, idx_d);
          end
        end else begin
          ram_wdata    = new_q;
          count_d      = count_q + CW'(1);
          res_d.status = StsInserted;
          res_d.count  = CNT_BITS'(count_d);
        end
      end
      InsLast: begin
        ram_we       = 1'b1;
        ram_waddr    = head_q;
        ram_wdata    = new_q;
        count_d      = count_q + CW'(1);
        res_d.status = StsInserted;
        res_d.count  = CNT_BITS'(count_d);
      end
      Done: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      if (state_q == Done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    new_q <= new_d;
    res_q <= res_d;
    if (state_q == Done && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SPQ_ASSERT(a_count_range, count_q <= DepthC, "queue count above depth")
  `SPQ_ASSERT_ALWAYS(a_head_range, !rst_ni || head_q <= AW'(DEPTH - 1),
    "head pointer out of range")
  `SPQ_ASSERT(a_walk_in_queue, state_q == InsWalk |-> {1'b0, idx_q} < (AW+1)'(count_q),
    "insert walk beyond held entries")
  `SPQ_ASSERT(a_full_refused,
    in_fire && in_data_i.func == FuncInsert && count_q == DepthC
      |=> state_q == Done && res_q.status == StsFull && $stable(count_q),
    "insert into full queue not refused")
  `SPQ_ASSERT(a_out_from_done, out_valid_q && !$past(out_valid_q) |-> $past(state_q) == Done,
    "result issued outside done state")

endmodule

### verif/sorted_priority_queue_unit_test.sv
module sorted_priority_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned QDEPTH = DEPTH_DEF;
  // Cycles with no beat on either side before the run is declared hung.
  // Slowest legal gap is an insert walking the full tail behind a stalled
  // output, far below this.
  localparam int unsigned HANG_LIMIT = 2000;
  // Quiet cycles after the last result, to catch stray beats.
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RANDOM_OPS = 1600;
  localparam int unsigned MAX_PRINTS = 40;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;

  sorted_priority_queue_unit #(
    .DEPTH(QDEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Shadow queue: sorted by priority, ties kept in arrival order.
  // Front of the queue is the next entry to leave.
  // ---------------------------------------------------------------------
  entry_t    shadow_q[$];
  out_beat_t pending_results[$];

  int unsigned n_mismatch = 0;
  int unsigned n_results  = 0;
  int unsigned n_sent     = 0;
  int unsigned n_inserted = 0;
  int unsigned n_removed  = 0;
  int unsigned n_full     = 0;
  int unsigned n_empty    = 0;
  int unsigned peak_fill  = 0;

  function automatic out_beat_t mk_result(status_e s, logic [PRIO_BITS-1:0] p,
                                          logic [TAG_BITS-1:0] t, int c);
    out_beat_t r;
    r.status       = s;
    r.out_priority = p;
    r.out_tag      = t;
    r.count        = CNT_BITS'(c);
    return r;
  endfunction

  // Applies one operation to the shadow queue, returns the result beat.
  function automatic out_beat_t queue_apply(in_beat_t op);
    out_beat_t r;
    entry_t    e;
    int        pos;
    r = '0;
    if (op.func == FuncInsert) begin
      if (shadow_q.size() >= QDEPTH) begin
        r.status = StsFull;
      end else begin
        // new entry goes behind every entry of equal or lower priority
        pos = 0;
        while (pos < shadow_q.size() && shadow_q[pos].prio <= op.priority_req) pos++;
        e.prio = op.priority_req;
        e.tag  = op.tag;
        shadow_q.insert(pos, e);
        r.status = StsInserted;
      end
    end else begin
      if (shadow_q.size() == 0) begin
        r.status = StsEmpty;
      end else begin
        e = shadow_q.pop_front();
        r.status       = StsRemoved;
        r.out_priority = e.prio;
        r.out_tag      = e.tag;
      end
    end
    r.count = CNT_BITS'(shadow_q.size());
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    if (n_mismatch < MAX_PRINTS)
      $display("[%0t] MISMATCH result #%0d: %s", $realtime, n_results, msg);
    n_mismatch++;
  endtask

  // ---------------------------------------------------------------------
  // Sender: bursts of random length, random gaps in between (or none
  // at all when no_gaps is set for the phase).
  // ---------------------------------------------------------------------
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;

  task automatic send_op(in_beat_t op, out_beat_t want, bit typed);
    out_beat_t guess;
    int        gap;
    in_data  <= op;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    // accepted at this edge
    guess = queue_apply(op);
    pending_results.push_back(typed ? want : guess);
    n_sent++;
    case (guess.status)
      StsInserted: n_inserted++;
      StsRemoved:  n_removed++;
      StsFull:     n_full++;
      default:     n_empty++;
    endcase
    if (shadow_q.size() > peak_fill) peak_fill = shadow_q.size();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic settle_queue();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall pattern switches after a random hold between
  // never stalling, random stalls, and a fixed on/off rhythm.
  // ---------------------------------------------------------------------
  int unsigned stall_mode  = 0;
  int unsigned stall_hold  = 0;
  int unsigned stall_phase = 0;

  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_hold = $urandom_range(50, 300);
    end else begin
      stall_hold--;
    end
    stall_phase = (stall_phase + 1) % 9;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (stall_phase < 5);
    endcase
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted result beat against the oldest
  // pending expectation, field by field.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat status=%0d count=%0d",
                                out_data.status, out_data.count));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          note_mismatch($sformatf("status got %0d want %0d",
                                  out_data.status, want.status));
        if (out_data.out_priority !== want.out_priority)
          note_mismatch($sformatf("priority got %0h want %0h",
                                  out_data.out_priority, want.out_priority));
        if (out_data.out_tag !== want.out_tag)
          note_mismatch($sformatf("tag got %0h want %0h",
                                  out_data.out_tag, want.out_tag));
        if (out_data.count !== want.count)
          note_mismatch($sformatf("count got %0d want %0d",
                                  out_data.count, want.count));
      end
      n_results++;
    end
  end

  // Watchdog: ends the run if neither side moves a beat for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("[%0t] hang: no beat for %0d cycles, %0d results pending",
                 $realtime, HANG_LIMIT, pending_results.size());
        $display("sorted_priority_queue_unit_test: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Directed table. Rows with typed=1 carry a result that is obvious from
  // the spec; the rest go through the shadow queue. reps>1 repeats the
  // row with priority stepping through 4 values and tag counting up.
  // ---------------------------------------------------------------------
  typedef struct {
    in_beat_t  op;
    int        reps;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t mk_row(logic f, logic [PRIO_BITS-1:0] p,
                                      logic [TAG_BITS-1:0] t, int reps,
                                      bit typed, out_beat_t want);
    dir_row_t row;
    row.op.func         = f;
    row.op.priority_req = p;
    row.op.tag          = t;
    row.reps            = reps;
    row.typed           = typed;
    row.want            = want;
    return row;
  endfunction

  initial begin
    in_beat_t    op;
    int          r;
    int          k;
    int          phase_len;
    int          ins_pct;
    int          prio_style;
    int          prio_base;
    int unsigned rand_sent;

    // empty remove, extremes in and out, then empty again
    dir_rows.push_back(mk_row(FuncRemove, 8'h00, 16'h0000, 1, 1,
                              mk_result(StsEmpty, 0, 0, 0)));
    dir_rows.push_back(mk_row(FuncInsert, 8'hFF, 16'hFFFF, 1, 1,
                              mk_result(StsInserted, 0, 0, 1)));
    dir_rows.push_back(mk_row(FuncInsert, 8'h00, 16'h0000, 1, 1,
                              mk_result(StsInserted, 0, 0, 2)));
    dir_rows.push_back(mk_row(FuncRemove, 8'hFF, 16'hFFFF, 1, 1,
                              mk_result(StsRemoved, 8'h00, 16'h0000, 1)));
    dir_rows.push_back(mk_row(FuncRemove, 8'h00, 16'h0000, 1, 1,
                              mk_result(StsRemoved, 8'hFF, 16'hFFFF, 0)));
    dir_rows.push_back(mk_row(FuncRemove, 8'h00, 16'h0000, 1, 1,
                              mk_result(StsEmpty, 0, 0, 0)));
    // ties must leave in arrival order; a lower value cuts ahead
    dir_rows.push_back(mk_row(FuncInsert, 8'h80, 16'h8000, 1, 1,
                              mk_result(StsInserted, 0, 0, 1)));
    dir_rows.push_back(mk_row(FuncInsert, 8'h80, 16'h0001, 1, 0, '0));
    dir_rows.push_back(mk_row(FuncInsert, 8'h7F, 16'h5555, 1, 0, '0));
    dir_rows.push_back(mk_row(FuncInsert, 8'h80, 16'hAAAA, 1, 0, '0));
    dir_rows.push_back(mk_row(FuncRemove, 8'h00, 16'h0000, 4, 0, '0));
    // fill to the brim, then knock on a full queue
    dir_rows.push_back(mk_row(FuncInsert, 8'h40, 16'h1000, QDEPTH, 0, '0));
    dir_rows.push_back(mk_row(FuncInsert, 8'h00, 16'h1234, 1, 1,
                              mk_result(StsFull, 0, 0, QDEPTH)));
    dir_rows.push_back(mk_row(FuncInsert, 8'hFF, 16'hFFFF, 1, 1,
                              mk_result(StsFull, 0, 0, QDEPTH)));
    // drain it all, then one more remove on empty
    dir_rows.push_back(mk_row(FuncRemove, 8'h00, 16'h0000, QDEPTH, 0, '0));
    dir_rows.push_back(mk_row(FuncRemove, 8'h00, 16'h0000, 1, 1,
                              mk_result(StsEmpty, 0, 0, 0)));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < dir_rows.size(); r++) begin
      for (k = 0; k < dir_rows[r].reps; k++) begin
        op = dir_rows[r].op;
        op.priority_req = op.priority_req + PRIO_BITS'(k % 4);
        op.tag          = op.tag + TAG_BITS'(k);
        send_op(op, dir_rows[r].want, dir_rows[r].typed);
      end
    end

    // let everything land before random traffic starts
    settle_queue();

    // Random phases. Each phase leans toward filling, draining or neither,
    // so the fill level sweeps between empty and full over and over.
    // Priority style: full range, a tight cluster (many ties), or extremes.
    rand_sent = 0;
    while (rand_sent < RANDOM_OPS) begin
      phase_len = $urandom_range(30, 150);
      case ($urandom_range(0, 3))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        2:       ins_pct = 50;
        default: ins_pct = 65;
      endcase
      prio_style = $urandom_range(0, 2);
      prio_base  = $urandom_range(0, 253);
      no_gaps    = ($urandom_range(0, 3) == 0);
      for (k = 0; k < phase_len && rand_sent < RANDOM_OPS; k++) begin
        op.func = ($urandom_range(0, 99) < ins_pct) ? FuncInsert : FuncRemove;
        case (prio_style)
          0:       op.priority_req = PRIO_BITS'($urandom_range(0, 255));
          1:       op.priority_req = PRIO_BITS'(prio_base + $urandom_range(0, 2));
          default: op.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        op.tag = TAG_BITS'($urandom_range(0, 65535));
        send_op(op, '0, 1'b0);
        rand_sent++;
      end
      if ($urandom_range(0, 4) == 0) settle_queue();
    end

    // wait out all results, then a quiet tail for stray beats
    settle_queue();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d ops: %0d inserts, %0d removes, %0d refused full, %0d refused empty",
             n_sent, n_inserted, n_removed, n_full, n_empty);
    $display("results checked %0d, peak fill %0d of %0d, mismatches %0d",
             n_results, peak_fill, QDEPTH, n_mismatch);
    if (n_mismatch == 0) begin
      $display("sorted_priority_queue_unit_test: done, clean");
    end else begin
      $display("sorted_priority_queue_unit_test: done, errors");
    end
    $finish;
  end

endmodule

### sorted_priority_queue_unit.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/sorted_priority_queue_unit.sv
verif/sorted_priority_queue_unit_test.sv
